// ===== sv/i2cms_pkg.sv =====
// Shared types, command codes and a helper function of the I2C master bit sequencer.
`default_nettype none
package i2cms_pkg;

  localparam int unsigned DATA_BITS = 8;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned TICK_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BCNT_W    = 4;

  // Command codes carried on the func field.
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SETUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COND  = 2'd3;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_START = 5'b00010,
    MODE_STOP  = 5'b00100,
    MODE_WRITE = 5'b01000,
    MODE_READ  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [TICK_W-1:0] setup_ticks;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic [TICK_W-1:0] cond_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 scl_release;
    logic                 sda_release;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 ack_level;
  } result_t;

  // A delay register holds a tick count; zero behaves as one. The counter
  // loads one less than the delay since the entry tick counts too.
  function automatic logic [TICK_W-1:0] span(input logic [TICK_W-1:0] r);
    span = (r == '0) ? '0 : r - 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== sv/i2cms_if.sv =====
// Handshake interfaces for the tick/command channel and the pin/result channel.
`default_nettype none
interface i2cms_cmd_if;
  import i2cms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [DATA_BITS-1:0] tx_byte;
  logic                 nak_out;
  logic                 sda_in;

  modport source (output valid, func, tx_byte, nak_out, sda_in, input ready);
  modport sink   (input valid, func, tx_byte, nak_out, sda_in, output ready);
endinterface

interface i2cms_res_if;
  import i2cms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 scl_release;
  logic                 sda_release;
  logic                 busy_res;
  logic                 done_res;
  logic [DATA_BITS-1:0] rx_byte;
  logic                 ack_level;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, rx_byte,
                  ack_level, input ready);
  modport sink   (input valid, scl_release, sda_release, busy_res, done_res, rx_byte,
                  ack_level, output ready);
endinterface
`default_nettype wire

// ===== sv/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer: one bus tick per beat in, pin levels out.
// The result beat for a tick is registered in the output buffer before it is presented.
// Throughput: one tick beat per cycle while the buffer has room; the two-entry result buffer absorbs one stalled beat.
// A tick beat is refused only while two result beats wait on the output.
// Reset (rst, synchronous, active high) returns the bus state to idle with both lines
// released and the timing registers to setup 1, high 4, low 1 and cond 2 ticks.
`default_nettype none
module i2c_master_bit_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  i2cms_cmd_if.sink                       cmd,
  i2cms_res_if.source                     res,
  input  logic                            cfg_we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cms_pkg::TICK_W-1:0]    cfg_wdata
);
  import i2cms_pkg::*;

  cfg_t    cfg;
  result_t step_result;
  result_t head;
  logic    room;
  logic    step;

  // A tick beat advances the bus state only when it is taken, so a stalled
  // tick leaves the line timing untouched.
  assign cmd.ready = room;
  assign step      = cmd.valid && room;

  i2cms_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // The sequencer works out the new bus state and the beat's result in the
  // same cycle; the result goes straight into the output buffer.
  i2cms_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .func    (cmd.func),
    .tx_byte (cmd.tx_byte),
    .nak_out (cmd.nak_out),
    .sda_in  (cmd.sda_in),
    .cfg     (cfg),
    .result  (step_result)
  );

  // The buffer keeps taking ticks while one result beat waits downstream.
  i2cms_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (step_result),
    .has_room   (room),
    .head_valid (res.valid),
    .pop        (res.valid && res.ready),
    .head_data  (head)
  );

  assign res.scl_release = head.scl_release;
  assign res.sda_release = head.sda_release;
  assign res.busy_res    = head.busy_res;
  assign res.done_res    = head.done_res;
  assign res.rx_byte     = head.rx_byte;
  assign res.ack_level   = head.ack_level;

endmodule
`default_nettype wire

// ===== sv/i2cms_cfg.sv =====
// Timing configuration registers of the I2C master bit sequencer.
`default_nettype none
module i2cms_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0] index,
  input  logic [i2cms_pkg::TICK_W-1:0]    wdata,
  output i2cms_pkg::cfg_t                 cfg
);
  import i2cms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks <= 4'd1;
      cfg.high_ticks  <= 4'd4;
      cfg.low_ticks   <= 4'd1;
      cfg.cond_ticks  <= 4'd2;
    end else if (we) begin
      case (index)
        REG_SETUP: cfg.setup_ticks <= wdata;
        REG_HIGH:  cfg.high_ticks  <= wdata;
        REG_LOW:   cfg.low_ticks   <= wdata;
        REG_COND:  cfg.cond_ticks  <= wdata;
        default:   cfg.setup_ticks <= cfg.setup_ticks;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/i2cms_core.sv =====
// Bus sequencing state and its one-tick update for start, stop, write and read.
`default_nettype none
module i2cms_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [i2cms_pkg::FUNC_W-1:0]    func,
  input  logic [i2cms_pkg::DATA_BITS-1:0] tx_byte,
  input  logic                            nak_out,
  input  logic                            sda_in,
  input  i2cms_pkg::cfg_t                 cfg,
  output i2cms_pkg::result_t              result
);
  import i2cms_pkg::*;

  mode_t                mode, mode_next;
  logic [1:0]           phase, phase_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [BCNT_W-1:0]    bit_count, bit_count_next;
  logic [DATA_BITS-1:0] shift_reg, shift_reg_next;
  logic                 scl_state, scl_state_next;
  logic                 sda_state, sda_state_next;
  logic                 ack_flag, ack_flag_next;
  logic                 nak_hold, nak_hold_next;
  logic [DATA_BITS-1:0] rx_hold, rx_hold_next;
  logic                 done;

  always_comb begin
    logic                 is_write;
    logic                 sent;
    logic [1:0]           ph;
    logic [BCNT_W-1:0]    bc;
    logic [DATA_BITS-1:0] sh;

    mode_next       = mode;
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    scl_state_next  = scl_state;
    sda_state_next  = sda_state;
    ack_flag_next   = ack_flag;
    nak_hold_next   = nak_hold;
    rx_hold_next    = rx_hold;
    done            = 1'b0;
    is_write        = (mode == MODE_WRITE);
    ph              = phase + 2'd1;
    bc              = bit_count + 1'b1;
    sh              = shift_reg;
    sent            = 1'b0;

    if (mode == MODE_IDLE) begin
      case (func)
        FUNC_START: begin
          mode_next       = MODE_START;
          phase_next      = 2'd0;
          sda_state_next  = 1'b1;
          tick_count_next = span(cfg.cond_ticks);
        end
        FUNC_STOP: begin
          mode_next       = MODE_STOP;
          phase_next      = 2'd0;
          scl_state_next  = 1'b0;
          tick_count_next = span(cfg.cond_ticks);
        end
        FUNC_WRITE: begin
          mode_next       = MODE_WRITE;
          bit_count_next  = '0;
          shift_reg_next  = tx_byte;
          phase_next      = 2'd0;
          sda_state_next  = tx_byte[DATA_BITS-1];
          tick_count_next = span(cfg.setup_ticks);
        end
        FUNC_READ: begin
          mode_next       = MODE_READ;
          bit_count_next  = '0;
          shift_reg_next  = '0;
          nak_hold_next   = nak_out;
          phase_next      = 2'd1;
          sda_state_next  = 1'b1;
          scl_state_next  = 1'b1;
          tick_count_next = span(cfg.high_ticks);
        end
        default: mode_next = MODE_IDLE;
      endcase
    end else if (tick_count != '0) begin
      tick_count_next = tick_count - 1'b1;
    end else if (mode == MODE_START) begin
      if (phase == 2'd3) begin
        done = 1'b1;
      end else begin
        phase_next      = ph;
        tick_count_next = span(cfg.cond_ticks);
        case (ph)
          2'd1:    scl_state_next = 1'b1;
          2'd2:    sda_state_next = 1'b0;
          default: scl_state_next = 1'b0;
        endcase
      end
    end else if (mode == MODE_STOP) begin
      phase_next      = ph;
      tick_count_next = span(cfg.cond_ticks);
      case (ph)
        2'd1:    sda_state_next = 1'b0;
        2'd2:    scl_state_next = 1'b1;
        default: sda_state_next = 1'b1;
      endcase
      if (ph == 2'd3) begin
        done = 1'b1;
      end
    end else if (phase == 2'd0) begin
      phase_next      = 2'd1;
      scl_state_next  = 1'b1;
      tick_count_next = span(cfg.high_ticks);
    end else if (phase == 2'd1) begin
      // Sample SDA on the last tick of the SCL high time when receiving.
      sent = is_write ? (bit_count < BCNT_W'(DATA_BITS)) : (bit_count >= BCNT_W'(DATA_BITS));
      if (!sent) begin
        if (is_write) begin
          ack_flag_next = sda_in;
        end else begin
          shift_reg_next = {shift_reg[DATA_BITS-2:0], sda_in};
        end
      end
      phase_next      = 2'd2;
      scl_state_next  = 1'b0;
      tick_count_next = span(cfg.low_ticks);
    end else begin
      if (is_write && (bit_count < BCNT_W'(DATA_BITS))) begin
        sh = {shift_reg[DATA_BITS-2:0], 1'b0};
      end
      shift_reg_next = sh;
      bit_count_next = bc;
      if (bc >= BCNT_W'(DATA_BITS + 1)) begin
        if (!is_write) begin
          rx_hold_next = shift_reg;
        end
        done = 1'b1;
      end else begin
        sent = is_write ? (bc < BCNT_W'(DATA_BITS)) : (bc >= BCNT_W'(DATA_BITS));
        if (sent) begin
          phase_next      = 2'd0;
          sda_state_next  = is_write ? sh[DATA_BITS-1] : nak_hold;
          tick_count_next = span(cfg.setup_ticks);
        end else begin
          phase_next      = 2'd1;
          sda_state_next  = 1'b1;
          scl_state_next  = 1'b1;
          tick_count_next = span(cfg.high_ticks);
        end
      end
    end

    if (done) begin
      mode_next       = MODE_IDLE;
      phase_next      = 2'd0;
      tick_count_next = '0;
      bit_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      phase      <= 2'd0;
      tick_count <= '0;
      bit_count  <= '0;
      shift_reg  <= '0;
      scl_state  <= 1'b1;
      sda_state  <= 1'b1;
      ack_flag   <= 1'b0;
      nak_hold   <= 1'b0;
      rx_hold    <= '0;
    end else if (step) begin
      mode       <= mode_next;
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      scl_state  <= scl_state_next;
      sda_state  <= sda_state_next;
      ack_flag   <= ack_flag_next;
      nak_hold   <= nak_hold_next;
      rx_hold    <= rx_hold_next;
    end
  end

  always_comb begin
    result.scl_release = scl_state_next;
    result.sda_release = sda_state_next;
    result.busy_res    = (mode_next != MODE_IDLE);
    result.done_res    = done;
    result.rx_byte     = rx_hold_next;
    result.ack_level   = ack_flag_next;
  end

endmodule
`default_nettype wire

// ===== sv/i2cms_obuf.sv =====
// Two-entry result buffer that decouples the tick input from the result output.
`default_nettype none
module i2cms_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  i2cms_pkg::result_t push_data,
  output logic               has_room,
  output logic               head_valid,
  input  logic               pop,
  output i2cms_pkg::result_t head_data
);
  import i2cms_pkg::*;

  logic    v0, v1;
  result_t d0, d1;

  assign has_room   = !v1;
  assign head_valid = v0;
  assign head_data  = d0;

  // A push only happens while the second slot is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop && push) begin
      v0 <= 1'b1;
    end else if (pop) begin
      v0 <= v1;
      v1 <= 1'b0;
    end else if (push) begin
      if (v0) begin
        v1 <= 1'b1;
      end else begin
        v0 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      d0 <= push_data;
    end else if (pop) begin
      d0 <= d1;
    end else if (push) begin
      if (v0) begin
        d1 <= push_data;
      end else begin
        d0 <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_i2c_master_bit_sequencer.sv =====
// Self-checking testbench of the I2C master bit sequencer: command sequences, timing settings.
`timescale 1ns / 100ps
module tb_i2c_master_bit_sequencer;
  import i2cms_pkg::*;

  // Generous ceiling, well above the slowest expected run.
  localparam int CYCLE_LIMIT = 100_000;
  // Cycles allowed after the last result beat.
  localparam int SETTLE_CYCLES = 4;
  // Highest value of the command field. Codes above FUNC_READ have no meaning.
  localparam logic [FUNC_W-1:0] FUNC_LAST = 3'd7;

  typedef enum {SDA_RANDOM, SDA_LOW, SDA_RELEASED} sda_drive_t;

  // Bit-exact model of the sequencer. It holds the pin levels that each tick beat must
  // produce, in the order in which the tick beats were taken.
  class bus_pin_scoreboard;
    logic [TICK_W-1:0]    t_setup, t_high, t_low, t_cond;
    mode_t                bus_mode;
    logic [2:0]           step;
    logic [TICK_W-1:0]    ticks_left;
    logic [BCNT_W-1:0]    bits_done;
    logic [DATA_BITS-1:0] shifter;
    logic                 scl, sda, ack;
    logic                 nak_latched;
    logic [DATA_BITS-1:0] rx_last;
    result_t              pins_due[$];
    int                   errors;
    int                   ticks;
    int                   checked;

    function new();
      t_setup = 4'd1;
      t_high = 4'd4;
      t_low = 4'd1;
      t_cond = 4'd2;
      bus_mode = MODE_IDLE;
      step = '0;
      ticks_left = '0;
      bits_done = '0;
      shifter = '0;
      scl = 1'b1;
      sda = 1'b1;
      ack = 1'b0;
      nak_latched = 1'b0;
      rx_last = '0;
      errors = 0;
      ticks = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] v);
      case (idx)
        REG_SETUP: t_setup = v;
        REG_HIGH:  t_high = v;
        REG_LOW:   t_low = v;
        REG_COND:  t_cond = v;
        default: ;
      endcase
    endfunction

    function bit busy();
      return bus_mode != MODE_IDLE;
    endfunction

    function int pending();
      return pins_due.size();
    endfunction

    // The counter is loaded with one less than the delay, as the entry tick counts too.
    // A delay of zero is treated as a delay of one.
    function logic [TICK_W-1:0] load_count(logic [TICK_W-1:0] d);
      return (d == '0) ? '0 : d - 1'b1;
    endfunction

    // Data bits of a write and the acknowledge bit of a read are driven by the master.
    function bit master_drives_bit();
      if (bus_mode == MODE_WRITE) return bits_done < DATA_BITS;
      return bits_done >= DATA_BITS;
    endfunction

    function void enter_bit();
      if (master_drives_bit()) begin
        step = 3'd0;
        sda = (bus_mode == MODE_WRITE) ? shifter[DATA_BITS-1] : nak_latched;
        ticks_left = load_count(t_setup);
      end else begin
        step = 3'd1;
        sda = 1'b1;
        scl = 1'b1;
        ticks_left = load_count(t_high);
      end
    endfunction

    // Pin change of each step of a start or stop condition.
    function void condition_step();
      if (bus_mode == MODE_START) begin
        case (step)
          3'd0: sda = 1'b1;
          3'd1: scl = 1'b1;
          3'd2: sda = 1'b0;
          default: scl = 1'b0;
        endcase
      end else begin
        case (step)
          3'd0: scl = 1'b0;
          3'd1: sda = 1'b0;
          3'd2: scl = 1'b1;
          default: sda = 1'b1;
        endcase
      end
    endfunction

    // Moves a running command on by one step once its delay has run out; true when done.
    function bit next_step(logic sda_in);
      if (bus_mode == MODE_START || bus_mode == MODE_STOP) begin
        if (bus_mode == MODE_START && step >= 3'd3) return 1'b1;
        step = step + 1'b1;
        condition_step();
        if (bus_mode == MODE_STOP && step >= 3'd3) return 1'b1;
        ticks_left = load_count(t_cond);
        return 1'b0;
      end
      if (step == 3'd0) begin
        step = 3'd1;
        scl = 1'b1;
        ticks_left = load_count(t_high);
        return 1'b0;
      end
      if (step == 3'd1) begin
        if (!master_drives_bit()) begin
          if (bus_mode == MODE_WRITE) ack = sda_in;
          else shifter = {shifter[DATA_BITS-2:0], sda_in};
        end
        step = 3'd2;
        scl = 1'b0;
        ticks_left = load_count(t_low);
        return 1'b0;
      end
      if (bus_mode == MODE_WRITE && bits_done < DATA_BITS) shifter = shifter << 1;
      bits_done = bits_done + 1'b1;
      if (bits_done >= DATA_BITS + 1) begin
        if (bus_mode == MODE_READ) rx_last = shifter;
        return 1'b1;
      end
      enter_bit();
      return 1'b0;
    endfunction

    function void note_tick(logic [FUNC_W-1:0] f, logic [DATA_BITS-1:0] tx, logic nak,
                            logic sda_in);
      result_t r;
      logic    fin;
      fin = 1'b0;
      ticks++;
      if (bus_mode == MODE_IDLE) begin
        case (f)
          FUNC_START, FUNC_STOP: begin
            bus_mode = (f == FUNC_START) ? MODE_START : MODE_STOP;
            step = 3'd0;
            condition_step();
            ticks_left = load_count(t_cond);
          end
          FUNC_WRITE, FUNC_READ: begin
            bus_mode = (f == FUNC_WRITE) ? MODE_WRITE : MODE_READ;
            bits_done = '0;
            if (f == FUNC_WRITE) begin
              shifter = tx;
            end else begin
              shifter = '0;
              nak_latched = nak;
            end
            enter_bit();
          end
          default: ;
        endcase
      end else if (ticks_left != '0) begin
        ticks_left = ticks_left - 1'b1;
      end else if (next_step(sda_in)) begin
        bus_mode = MODE_IDLE;
        step = 3'd0;
        ticks_left = '0;
        bits_done = '0;
        fin = 1'b1;
      end
      r.scl_release = scl;
      r.sda_release = sda;
      r.busy_res = (bus_mode != MODE_IDLE);
      r.done_res = fin;
      r.rx_byte = rx_last;
      r.ack_level = ack;
      pins_due.push_back(r);
    endfunction

    task report(string msg);
      $display("result beat %0d: %s", checked, msg);
      errors++;
    endtask

    task check_pins(result_t got);
      result_t want;
      if (pins_due.size() == 0) begin
        report("result beat with no tick waiting for it");
      end else begin
        want = pins_due.pop_front();
        if (got.scl_release !== want.scl_release)
          report($sformatf("scl_release want %0d got %0d", want.scl_release, got.scl_release));
        if (got.sda_release !== want.sda_release)
          report($sformatf("sda_release want %0d got %0d", want.sda_release, got.sda_release));
        if (got.busy_res !== want.busy_res)
          report($sformatf("busy_res want %0d got %0d", want.busy_res, got.busy_res));
        if (got.done_res !== want.done_res)
          report($sformatf("done_res want %0d got %0d", want.done_res, got.done_res));
        if (got.rx_byte !== want.rx_byte)
          report($sformatf("rx_byte want %02h got %02h", want.rx_byte, got.rx_byte));
        if (got.ack_level !== want.ack_level)
          report($sformatf("ack_level want %0d got %0d", want.ack_level, got.ack_level));
      end
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_wdata;

  i2cms_cmd_if cmd_ch ();
  i2cms_res_if res_ch ();

  i2c_master_bit_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bus_pin_scoreboard sb = new();

  // Percentage of cycles on which each side holds back. Changed between phases.
  int         tx_idle_pct = 17;
  int         rx_idle_pct = 86;
  sda_drive_t sda_drive = SDA_RANDOM;
  int         cmds_sent = 0;
  int         settings_used = 1;
  int         cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result beat ends the run here.
  initial begin : watchdog
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("no progress within %0d cycles", CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Result side. Ready is changed on the falling edge and a beat is taken and checked on
  // the rising edge, so the stalls land on every step of the bus waveform.
  initial begin : result_sink
    result_t got;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got = {res_ch.scl_release, res_ch.sda_release, res_ch.busy_res, res_ch.done_res,
               res_ch.rx_byte, res_ch.ack_level};
        sb.check_pins(got);
      end
      @(negedge clk);
      res_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Presents one tick beat, entered and left at a falling edge. Valid is left high on
  // return, so back-to-back beats never see valid dropped and raised in the same step.
  task automatic send_tick(input logic [FUNC_W-1:0] f, input logic [DATA_BITS-1:0] tx,
                           input logic nak);
    logic s;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    case (sda_drive)
      SDA_LOW:      s = 1'b0;
      SDA_RELEASED: s = 1'b1;
      default:      s = 1'($urandom_range(0, 1));
    endcase
    cmd_ch.func = f;
    cmd_ch.tx_byte = tx;
    cmd_ch.nak_out = nak;
    cmd_ch.sda_in = s;
    cmd_ch.valid = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_tick(f, tx, nak, s);
    @(negedge clk);
  endtask

  // While a command runs the command field is ignored, so it mostly carries nothing and
  // sometimes a stray code, which must have no effect.
  function automatic logic [FUNC_W-1:0] busy_noise();
    if ($urandom_range(0, 9) < 7) return FUNC_NONE;
    return FUNC_W'($urandom_range(0, FUNC_LAST));
  endfunction

  // Runs out the ticks of the command in progress, then issues the next one. Now and then
  // an empty tick goes in while the bus is idle, as a real driver would leave.
  task automatic issue_cmd(input logic [FUNC_W-1:0] f, input logic [DATA_BITS-1:0] tx,
                           input logic nak);
    while (sb.busy())
      send_tick(busy_noise(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0)
      send_tick(FUNC_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_tick(f, tx, nak);
    cmds_sent++;
  endtask

  task automatic finish_commands();
    while (sb.busy())
      send_tick(busy_noise(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    cmd_ch.valid = 1'b0;
  endtask

  // A well-formed transfer: start, a few bytes either way, and usually a stop. Leaving the
  // stop out gives a repeated start at the next transfer.
  task automatic bus_transaction();
    int n;
    n = $urandom_range(1, 4);
    issue_cmd(FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat (n) begin
      if ($urandom_range(0, 1))
        issue_cmd(FUNC_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else
        issue_cmd(FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 9) != 0)
      issue_cmd(FUNC_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_timing_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TICK_W-1:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  // Timing registers change only with the bus idle and every result beat back, plus a
  // settling wait of SETTLE_CYCLES.
  task automatic set_timing(input logic [TICK_W-1:0] su, input logic [TICK_W-1:0] hi,
                            input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] co);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    write_timing_reg(REG_SETUP, su);
    write_timing_reg(REG_HIGH, hi);
    write_timing_reg(REG_LOW, lo);
    write_timing_reg(REG_COND, co);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Mostly whole transfers with random content; the rest are lone commands with any code,
  // including the unused ones and a read or stop with no start before it.
  task automatic run_phase(input logic [TICK_W-1:0] su, input logic [TICK_W-1:0] hi,
                           input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] co,
                           input int n_cmds);
    int first;
    set_timing(su, hi, lo, co);
    first = cmds_sent;
    while (cmds_sent - first < n_cmds) begin
      if ($urandom_range(0, 99) < 75)
        bus_transaction();
      else
        issue_cmd(FUNC_W'($urandom_range(0, FUNC_LAST)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    end
    finish_commands();
  endtask

  // A short transfer at the reset timing, with the acknowledge bit held low.
  task automatic directed_reset_timing();
    issue_cmd(FUNC_NONE, 8'h00, 1'b0);
    issue_cmd(FUNC_START, 8'h00, 1'b0);
    sda_drive = SDA_LOW;
    issue_cmd(FUNC_WRITE, 8'h00, 1'b0);
    sda_drive = SDA_RANDOM;
    issue_cmd(FUNC_STOP, 8'h00, 1'b0);
    finish_commands();
  endtask

  // Directed transfers at the shortest timing: byte extremes, both acknowledge levels,
  // reads of all ones and all zeros with ACK and NAK, the unused command codes, a stop and
  // a read with no start, and a repeated start.
  task automatic directed_fast();
    int f;
    issue_cmd(FUNC_START, 8'h00, 1'b0);
    sda_drive = SDA_RELEASED;
    issue_cmd(FUNC_WRITE, 8'hFF, 1'b1);
    sda_drive = SDA_RANDOM;
    issue_cmd(FUNC_WRITE, 8'h80, 1'b0);
    issue_cmd(FUNC_WRITE, 8'h01, 1'b0);
    issue_cmd(FUNC_WRITE, 8'hFE, 1'b1);
    sda_drive = SDA_RELEASED;
    issue_cmd(FUNC_READ, 8'h00, 1'b0);
    sda_drive = SDA_LOW;
    issue_cmd(FUNC_READ, 8'hFF, 1'b1);
    sda_drive = SDA_RANDOM;
    issue_cmd(FUNC_READ, 8'h5A, 1'b0);
    issue_cmd(FUNC_STOP, 8'h00, 1'b0);
    for (f = FUNC_READ + 1; f <= FUNC_LAST; f++)
      issue_cmd(FUNC_W'(f), 8'hA5, 1'b1);
    issue_cmd(FUNC_STOP, 8'h00, 1'b0);
    issue_cmd(FUNC_READ, 8'h00, 1'b1);
    issue_cmd(FUNC_START, 8'h00, 1'b0);
    issue_cmd(FUNC_WRITE, 8'($urandom_range(0, 255)), 1'b0);
    issue_cmd(FUNC_START, 8'h00, 1'b0);
    issue_cmd(FUNC_READ, 8'h00, 1'b1);
    issue_cmd(FUNC_STOP, 8'h00, 1'b0);
    finish_commands();
  endtask

  // Start and stop with every delay at its largest value.
  task automatic max_delay_conditions();
    set_timing(4'd15, 4'd15, 4'd15, 4'd15);
    issue_cmd(FUNC_START, 8'h00, 1'b0);
    issue_cmd(FUNC_STOP, 8'h00, 1'b0);
    finish_commands();
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SETUP;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = FUNC_NONE;
    cmd_ch.tx_byte = '0;
    cmd_ch.nak_out = 1'b0;
    cmd_ch.sda_in = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // First third: the sender rarely waits, the receiver mostly stalls.
    tx_idle_pct = 17;
    rx_idle_pct = 86;
    directed_reset_timing();
    set_timing(4'd1, 4'd1, 4'd1, 4'd1);
    directed_fast();
    // Zero in every register must behave as one.
    run_phase(4'd0, 4'd0, 4'd0, 4'd0, 4);

    // Second third: the other way round.
    tx_idle_pct = 86;
    rx_idle_pct = 17;
    run_phase(4'($urandom_range(1, 2)), 4'($urandom_range(1, 2)), 4'($urandom_range(1, 2)),
              4'($urandom_range(1, 2)), 4);
    max_delay_conditions();

    // Last third: both sides at full rate.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(4'($urandom_range(1, 2)), 4'($urandom_range(1, 2)), 4'($urandom_range(1, 2)),
              4'($urandom_range(1, 2)), 5);

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d commands as %0d tick beats, %0d result beats checked, %0d timings.",
             cmds_sent, sb.ticks, sb.checked, settings_used);
    $display("Included stray and unused codes, commands while busy, zero and maximum delays.");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
